[rtl/qbcg_pkg.sv]
// ----------------------------------------------------------------------------
// qbcg_pkg
// Shared types and constants of the queued blink code generator.
// ----------------------------------------------------------------------------
package qbcg_pkg;

  // Default sizing
  localparam int unsigned QUEUE_DEPTH_DEF = 8;
  localparam int unsigned TIMER_BITS_DEF  = 16;

  // Field widths
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned IN_ARG_W  = 16;
  localparam int unsigned COUNT_W   = 10;
  localparam int unsigned DELAY_W   = 14;
  localparam int unsigned TICK_W    = 10;
  localparam int unsigned ON_TIME_W = 14;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned STATE_W   = 2;
  localparam int unsigned PENDING_W = 4;

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Enqueue limits and reset values
  localparam logic [IN_ARG_W-1:0]  COUNT_MIN     = 16'd1;
  localparam logic [IN_ARG_W-1:0]  COUNT_MAX     = 16'd1000;
  localparam logic [IN_ARG_W-1:0]  DELAY_MIN     = 16'd10;
  localparam logic [IN_ARG_W-1:0]  DELAY_MAX     = 16'd10000;
  localparam logic [COUNT_W-1:0]   BLINKS_SAT    = 10'd1023;
  localparam logic [TICK_W-1:0]    TICK_RESET    = 10'd10;
  localparam logic [ON_TIME_W-1:0] ON_TIME_RESET = 14'd200;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ENQUEUE = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_LED_ON  = 3'd3,
    OP_LED_OFF = 3'd4,
    OP_TOGGLE  = 3'd5
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [STATE_W-1:0] {
    FSM_IDLE = 2'd0,
    FSM_ON   = 2'd1,
    FSM_OFF  = 2'd2,
    FSM_WAIT = 2'd3
  } fsm_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_HIGH = 2'd0,
    CFG_TICK_MS     = 2'd1,
    CFG_ON_TIME_MS  = 2'd2
  } cfg_e;

  // One queued blink command
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DELAY_W-1:0] delay;
  } cmd_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctrl_t;

  // One result transfer
  typedef struct packed {
    logic                 led_level;
    logic [STATUS_W-1:0]  status;
    logic [STATE_W-1:0]   fsm_state;
    logic                 busy;
    logic [PENDING_W-1:0] pending;
  } result_t;

endpackage

[rtl/qbcg_fifo.sv]
// ----------------------------------------------------------------------------
// qbcg_fifo
// Command queue with a registered head-of-queue read.
// ----------------------------------------------------------------------------
module qbcg_fifo #(
  parameter int unsigned QUEUE_DEPTH = qbcg_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qbcg_pkg::q_ctrl_t ctrl_i,
  input  qbcg_pkg::cmd_t    wdata_i,
  output qbcg_pkg::cmd_t    head_o,
  output logic [CNT_W-1:0]  count_o,
  output logic [CNT_W-1:0]  count_next_o
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  qbcg_pkg::cmd_t mem_q [QUEUE_DEPTH];
  qbcg_pkg::cmd_t head_q;

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (ctrl_i.pop) begin
        rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (ctrl_i.push && !ctrl_i.pop) begin
        count_d = count_q + CNT_W'(1);
      end else if (!ctrl_i.push && ctrl_i.pop) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage; head tracks mem at the read pointer, bypassing a same-cycle write
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (ctrl_i.push && (wr_ptr_q == rd_ptr_d)) begin
      head_q <= wdata_i;
    end else begin
      head_q <= mem_q[rd_ptr_d];
    end
  end

  assign head_o       = head_q;
  assign count_o      = count_q;
  assign count_next_o = count_d;

endmodule

[rtl/queued_blink_code_generator.sv]
// ----------------------------------------------------------------------------
// queued_blink_code_generator
// Queues blink commands and plays them on one LED pin with an
// Idle/On/Off/Wait sequencer advanced by tick items.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------
//  input     in         in_valid_i/in_stall_o  opcode_i, flash_count_i,
//                                              gap_ms_i
//  result    out        out_valid_o/out_stall_i led_level_o, status_o,
//                                              fsm_state_o, busy_res_o,
//                                              pending_o
//  config    in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//
//  - One item per cycle while not stalled: every opcode is a single
//    compare-and-update of the sequencer registers and queue pointers, done in
//    the cycle of the transfer. Each accepted item gives one registered result.
//  - A two-entry result buffer lets input transfers continue while one result
//    waits; in_stall_o rises only when both entries are held.
//  - Reset clears control state; queue storage is not cleared (never read
//    before it is written). No clearing pass, the block is ready at once.
//
module queued_blink_code_generator #(
  parameter int unsigned QUEUE_DEPTH = qbcg_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TIMER_BITS  = qbcg_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [qbcg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [qbcg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [qbcg_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [qbcg_pkg::IN_ARG_W-1:0]       flash_count_i,
  input  logic [qbcg_pkg::IN_ARG_W-1:0]       gap_ms_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                led_level_o,
  output logic [qbcg_pkg::STATUS_W-1:0]       status_o,
  output logic [qbcg_pkg::STATE_W-1:0]        fsm_state_o,
  output logic                                busy_res_o,
  output logic [qbcg_pkg::PENDING_W-1:0]      pending_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                             active_high_q;
  logic [qbcg_pkg::TICK_W-1:0]      tick_ms_q;
  logic [qbcg_pkg::ON_TIME_W-1:0]   on_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_high_q <= 1'b1;
      tick_ms_q     <= qbcg_pkg::TICK_RESET;
      on_time_q     <= qbcg_pkg::ON_TIME_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qbcg_pkg::CFG_ACTIVE_HIGH: active_high_q <= cfg_wdata_i[0];
        qbcg_pkg::CFG_TICK_MS:     tick_ms_q     <= cfg_wdata_i[qbcg_pkg::TICK_W-1:0];
        qbcg_pkg::CFG_ON_TIME_MS:  on_time_q     <= cfg_wdata_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  qbcg_pkg::fsm_e                 state_q, state_d;
  logic [TIMER_BITS-1:0]          blink_tmr_q, blink_tmr_d;
  logic [TIMER_BITS-1:0]          wait_tmr_q, wait_tmr_d;
  logic [qbcg_pkg::COUNT_W-1:0]   blinks_q, blinks_d;
  logic [qbcg_pkg::COUNT_W-1:0]   act_count_q, act_count_d;
  logic [qbcg_pkg::DELAY_W-1:0]   act_delay_q, act_delay_d;
  logic                           pin_q, pin_d;

  logic                           in_xfer;
  logic                           out_xfer;

  qbcg_pkg::q_ctrl_t              q_ctrl;
  qbcg_pkg::cmd_t                 q_head;
  qbcg_pkg::cmd_t                 new_cmd;
  qbcg_pkg::cmd_t                 start_cmd;
  logic                           start;
  logic [CNT_W-1:0]               q_count;
  logic [CNT_W-1:0]               q_count_next;
  qbcg_pkg::status_e              status;

  // Saturating timer increments
  logic [TIMER_BITS:0]            blink_sum, wait_sum;
  logic [TIMER_BITS-1:0]          blink_inc, wait_inc;
  logic [TIMER_BITS-1:0]          on_ext, delay_ext;
  logic [qbcg_pkg::COUNT_W-1:0]   blinks_inc;
  logic                           enq_ok;

  assign blink_sum = {1'b0, blink_tmr_q} + (TIMER_BITS + 1)'(tick_ms_q);
  assign wait_sum  = {1'b0, wait_tmr_q} + (TIMER_BITS + 1)'(tick_ms_q);
  assign blink_inc = blink_sum[TIMER_BITS] ? '1 : blink_sum[TIMER_BITS-1:0];
  assign wait_inc  = wait_sum[TIMER_BITS] ? '1 : wait_sum[TIMER_BITS-1:0];
  assign on_ext    = TIMER_BITS'(on_time_q);
  assign delay_ext = TIMER_BITS'(act_delay_q);
  assign blinks_inc = (blinks_q == qbcg_pkg::BLINKS_SAT) ? blinks_q
                                                         : blinks_q + qbcg_pkg::COUNT_W'(1);

  // Parameter check on the raw 16-bit fields, before truncation
  assign enq_ok = (flash_count_i >= qbcg_pkg::COUNT_MIN) &&
                  (flash_count_i <= qbcg_pkg::COUNT_MAX) &&
                  (gap_ms_i >= qbcg_pkg::DELAY_MIN) &&
                  (gap_ms_i <= qbcg_pkg::DELAY_MAX);

  assign new_cmd.count = flash_count_i[qbcg_pkg::COUNT_W-1:0];
  assign new_cmd.delay = gap_ms_i[qbcg_pkg::DELAY_W-1:0];

  always_comb begin
    state_d     = state_q;
    blink_tmr_d = blink_tmr_q;
    wait_tmr_d  = wait_tmr_q;
    blinks_d    = blinks_q;
    act_count_d = act_count_q;
    act_delay_d = act_delay_q;
    pin_d       = pin_q;
    q_ctrl      = '0;
    status      = qbcg_pkg::ST_OK;
    start       = 1'b0;
    start_cmd   = q_head;

    if (in_xfer) begin
      case (opcode_i)
        qbcg_pkg::OP_TICK: begin
          unique case (state_q)
            qbcg_pkg::FSM_IDLE: begin
              if (q_count != '0) begin
                start      = 1'b1;
                q_ctrl.pop = 1'b1;
              end
            end
            qbcg_pkg::FSM_ON: begin
              blink_tmr_d = blink_inc;
              if (blink_inc >= on_ext) begin
                pin_d       = ~active_high_q;
                blink_tmr_d = '0;
                blinks_d    = blinks_inc;
                if (blinks_inc >= act_count_q) begin
                  state_d    = qbcg_pkg::FSM_WAIT;
                  wait_tmr_d = '0;
                end else begin
                  state_d = qbcg_pkg::FSM_OFF;
                end
              end
            end
            qbcg_pkg::FSM_OFF: begin
              blink_tmr_d = blink_inc;
              if (blink_inc >= delay_ext) begin
                state_d     = qbcg_pkg::FSM_ON;
                pin_d       = active_high_q;
                blink_tmr_d = '0;
              end
            end
            qbcg_pkg::FSM_WAIT: begin
              wait_tmr_d = wait_inc;
              if (wait_inc >= on_ext) begin
                if (q_count != '0) begin
                  start      = 1'b1;
                  q_ctrl.pop = 1'b1;
                end else begin
                  state_d    = qbcg_pkg::FSM_IDLE;
                  wait_tmr_d = '0;
                end
              end
            end
            default: ;
          endcase
        end
        qbcg_pkg::OP_ENQUEUE: begin
          if (!enq_ok) begin
            status = qbcg_pkg::ST_INVALID;
          end else if (q_count >= CNT_FULL) begin
            status = qbcg_pkg::ST_FULL;
          end else if (state_q == qbcg_pkg::FSM_IDLE && q_count == '0) begin
            // empty and idle: the new command starts straight away
            start     = 1'b1;
            start_cmd = new_cmd;
          end else begin
            q_ctrl.push = 1'b1;
            if (state_q == qbcg_pkg::FSM_IDLE) begin
              start      = 1'b1;
              q_ctrl.pop = 1'b1;
            end
          end
        end
        qbcg_pkg::OP_CLEAR: begin
          q_ctrl.clear = 1'b1;
          state_d      = qbcg_pkg::FSM_IDLE;
          blink_tmr_d  = '0;
          wait_tmr_d   = '0;
          blinks_d     = '0;
          act_count_d  = '0;
          act_delay_d  = '0;
        end
        qbcg_pkg::OP_LED_ON:  pin_d = active_high_q;
        qbcg_pkg::OP_LED_OFF: pin_d = ~active_high_q;
        qbcg_pkg::OP_TOGGLE:  pin_d = ~pin_q;
        default: ;  // unused opcodes do nothing
      endcase

      // Command start: fresh phase, timers and blink count
      if (start) begin
        act_count_d = start_cmd.count;
        act_delay_d = start_cmd.delay;
        blinks_d    = '0;
        blink_tmr_d = '0;
        wait_tmr_d  = '0;
        state_d     = qbcg_pkg::FSM_ON;
        pin_d       = active_high_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qbcg_pkg::FSM_IDLE;
      blink_tmr_q <= '0;
      wait_tmr_q  <= '0;
      blinks_q    <= '0;
      act_count_q <= '0;
      act_delay_q <= '0;
      pin_q       <= 1'b0;  // dark with the reset polarity (active high)
    end else begin
      state_q     <= state_d;
      blink_tmr_q <= blink_tmr_d;
      wait_tmr_q  <= wait_tmr_d;
      blinks_q    <= blinks_d;
      act_count_q <= act_count_d;
      act_delay_q <= act_delay_d;
      pin_q       <= pin_d;
    end
  end

  qbcg_fifo #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (q_ctrl),
    .wdata_i      (new_cmd),
    .head_o       (q_head),
    .count_o      (q_count),
    .count_next_o (q_count_next)
  );

  // --------------------------------------------------------------------------
  // Result buffer: two entries, entry 0 is presented
  // --------------------------------------------------------------------------
  qbcg_pkg::result_t res_new;
  qbcg_pkg::result_t res0_q, res1_q;
  logic              v0_q, v1_q;

  assign res_new.led_level = pin_d;
  assign res_new.status    = status;
  assign res_new.fsm_state = state_d;
  assign res_new.busy      = (state_d != qbcg_pkg::FSM_IDLE);
  assign res_new.pending   = qbcg_pkg::PENDING_W'(q_count_next);

  assign in_stall_o = v1_q;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = v0_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (out_xfer) begin
        if (v1_q) begin
          v1_q <= in_xfer;
        end else begin
          v0_q <= in_xfer;
        end
      end else if (in_xfer) begin
        if (v0_q) begin
          v1_q <= 1'b1;
        end else begin
          v0_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_xfer) begin
      if (v1_q) begin
        res0_q <= res1_q;
        if (in_xfer) begin
          res1_q <= res_new;
        end
      end else if (in_xfer) begin
        res0_q <= res_new;
      end
    end else if (in_xfer) begin
      if (v0_q) begin
        res1_q <= res_new;
      end else begin
        res0_q <= res_new;
      end
    end
  end

  assign out_valid_o = v0_q;
  assign led_level_o = res0_q.led_level;
  assign status_o    = res0_q.status;
  assign fsm_state_o = res0_q.fsm_state;
  assign busy_res_o  = res0_q.busy;
  assign pending_o   = res0_q.pending;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Stall only with buffer entry 0 held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with result buffer not full");

  // Busy flag agrees with the reported state
  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (busy_res_o == (fsm_state_o != qbcg_pkg::FSM_IDLE)))
    else $error("busy flag disagrees with state");

  // A running command always has a nonzero blink count
  a_active_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != qbcg_pkg::FSM_IDLE) |-> (act_count_q != '0))
    else $error("sequencer running with zero blink count");

  // Queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CNT_FULL)
    else $error("queue count above depth");

  // Idle implies an empty queue
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qbcg_pkg::FSM_IDLE) |-> (q_count == '0))
    else $error("idle with commands waiting");

endmodule
